>>> rtl/usb_host_vendor_status_registers_assert.svh
// Assertion macros used by the checker of the vendor status register block.
`ifndef USB_HOST_VENDOR_STATUS_REGISTERS_ASSERT_SVH
`define USB_HOST_VENDOR_STATUS_REGISTERS_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UHVSR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UHVSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define UHVSR_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/uhvsr_pkg.sv
// ----------------------------------------------------------------------------
// uhvsr_pkg
// Types and constants of the vendor status register block.
// ----------------------------------------------------------------------------
package uhvsr_pkg;

  // Request kinds.
  localparam logic [1:0] OP_READ       = 2'd0;
  localparam logic [1:0] OP_WRITE      = 2'd1;
  localparam logic [1:0] OP_MEDIA_ERR  = 2'd2;
  localparam logic [1:0] OP_DESC_ERR   = 2'd3;

  // Register word indexes (byte address bits 11:2).
  localparam logic [9:0] WORD_CTL    = 10'h000;
  localparam logic [9:0] WORD_STATUS = 10'h001;
  localparam logic [9:0] WORD_HUB    = 10'h00d;

  localparam logic [31:0] CTL_RESET  = 32'h9000_0014;
  localparam logic [31:0] CTL_WRMASK = 32'hff01_03ff;
  localparam logic [11:0] CNT_MAX    = 12'hfff;

  // Status word bit positions.
  localparam int STAT_OVFL_BIT  = 16;
  localparam int STAT_DESC_BIT  = 18;
  localparam int STAT_SCHED_BIT = 20;

  // Root hub port state codes.
  localparam logic [3:0] PORT_UNPOWERED    = 4'h8;
  localparam logic [3:0] PORT_DISCONNECTED = 4'ha;
  localparam logic [3:0] PORT_RESETTING    = 4'h2;
  localparam logic [3:0] PORT_SUSPENDED    = 4'hc;
  localparam logic [3:0] PORT_ENABLED      = 4'he;
  localparam logic [3:0] PORT_DISABLED     = 4'hb;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] address;
    logic [2:0]  access_size;
    logic [31:0] write_data;
    logic [8:0]  port_one_control;
    logic [8:0]  port_two_control;
    logic        schedule_overrun;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        big_endian_mode;
    logic        consistency_check_mode;
    logic        clear_overrun;
  } out_item_t;

  // Architectural state. Only the counter, overflow and descriptor flags of
  // the status word can ever be set, so only those are kept.
  typedef struct packed {
    logic [31:0] control_word;
    logic [11:0] media_count;
    logic        overflow_flag;
    logic        descriptor_flag;
  } regs_t;

  function automatic logic [31:0] size_mask(input logic [2:0] size);
    logic [31:0] m;
    unique case (size)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic [3:0] port_code(input logic [8:0] ctl);
    logic [3:0] c;
    priority if (!ctl[8]) c = PORT_UNPOWERED;
    else if (!ctl[0])     c = PORT_DISCONNECTED;
    else if (ctl[4])      c = PORT_RESETTING;
    else if (ctl[2])      c = PORT_SUSPENDED;
    else if (ctl[1])      c = PORT_ENABLED;
    else                  c = PORT_DISABLED;
    return c;
  endfunction

endpackage

>>> rtl/uhvsr_exec.sv
// ----------------------------------------------------------------------------
// uhvsr_exec
// Decodes one request against the current registers and forms the next
// register values and the result.
// ----------------------------------------------------------------------------
module uhvsr_exec (
  input  uhvsr_pkg::in_item_t  item,
  input  uhvsr_pkg::regs_t     regs,
  input  logic [3:0]           port_count,
  output uhvsr_pkg::regs_t     regs_nxt,
  output uhvsr_pkg::out_item_t result
);

  logic [9:0]  word_idx;
  logic [4:0]  shamt;
  logic [31:0] smask;
  logic [31:0] lane;
  logic [31:0] wdata;
  logic [31:0] rword;
  logic        clr;

  assign word_idx = item.address[11:2];
  assign shamt    = {item.address[1:0], 3'b000};
  assign smask    = uhvsr_pkg::size_mask(item.access_size);
  // A full-word access writes every lane no matter the byte offset.
  assign lane     = (item.access_size >= 3'd4) ? 32'hffff_ffff : (smask << shamt);
  assign wdata    = (item.write_data << shamt) & lane;

  always_comb begin
    rword = 32'h0;
    priority if (word_idx == uhvsr_pkg::WORD_CTL) begin
      rword = regs.control_word;
    end else if (word_idx == uhvsr_pkg::WORD_STATUS) begin
      rword[11:0]                      = regs.media_count;
      rword[uhvsr_pkg::STAT_OVFL_BIT]  = regs.overflow_flag;
      rword[uhvsr_pkg::STAT_DESC_BIT]  = regs.descriptor_flag;
      rword[uhvsr_pkg::STAT_SCHED_BIT] = item.schedule_overrun;
    end else if (word_idx == uhvsr_pkg::WORD_HUB) begin
      if (port_count >= 4'd1) rword[3:0]  = uhvsr_pkg::port_code(item.port_one_control);
      if (port_count >= 4'd2) rword[11:8] = uhvsr_pkg::port_code(item.port_two_control);
    end else begin
      rword = 32'h0;
    end
  end

  always_comb begin
    regs_nxt = regs;
    clr      = 1'b0;
    unique case (item.operation)
      uhvsr_pkg::OP_READ: begin
        regs_nxt = regs;
      end
      uhvsr_pkg::OP_WRITE: begin
        if (word_idx == uhvsr_pkg::WORD_CTL) begin
          regs_nxt.control_word = (regs.control_word & ~lane) |
                                  (wdata & uhvsr_pkg::CTL_WRMASK);
        end else if (word_idx == uhvsr_pkg::WORD_STATUS) begin
          if (|wdata[11:0]) regs_nxt.media_count = 12'h000;
          if (wdata[uhvsr_pkg::STAT_OVFL_BIT]) regs_nxt.overflow_flag = 1'b0;
          if (wdata[uhvsr_pkg::STAT_DESC_BIT]) regs_nxt.descriptor_flag = 1'b0;
          clr = wdata[uhvsr_pkg::STAT_SCHED_BIT];
        end
      end
      uhvsr_pkg::OP_MEDIA_ERR: begin
        if (regs.media_count == uhvsr_pkg::CNT_MAX) regs_nxt.overflow_flag = 1'b1;
        else regs_nxt.media_count = regs.media_count + 12'd1;
      end
      uhvsr_pkg::OP_DESC_ERR: begin
        regs_nxt.descriptor_flag = 1'b1;
      end
      default: begin
        regs_nxt = regs;
      end
    endcase
  end

  assign result.read_data = (item.operation == uhvsr_pkg::OP_READ) ?
                            ((rword >> shamt) & smask) : 32'h0;
  assign result.big_endian_mode        = regs_nxt.control_word[0];
  assign result.consistency_check_mode = regs_nxt.control_word[1];
  assign result.clear_overrun          = clr;

endmodule

>>> rtl/usb_host_vendor_status_registers.sv
// ----------------------------------------------------------------------------
// usb_host_vendor_status_registers
// Vendor control and status registers beside a USB host controller.
// ----------------------------------------------------------------------------
//
// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+---------------------------
// in_     | input     | in_valid / in_ready     | in_data  (uhvsr_pkg::in_item_t)
// out_    | output    | out_valid / out_ready   | out_data (uhvsr_pkg::out_item_t)
// cfg_    | input     | cfg_valid / cfg_ready   | cfg_data (port count, 4 bits)
//
// A request is held in the input register and then moves into the result
// register, and one request is taken per cycle while nothing stalls. The
// result register is the only place that can stall: when it holds an untaken
// result, the input register waits and in_ready falls. Reset (rst_n low,
// synchronous) empties both registers, loads the control word with its reset
// value, clears the status word, and sets the port count to three. The
// configuration port is always ready.
//
module usb_host_vendor_status_registers (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  uhvsr_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output uhvsr_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [3:0]           cfg_data
);

  // Input register stage.
  logic                 in_valid_r;
  uhvsr_pkg::in_item_t  in_item_r;

  // Result register stage.
  logic                 out_valid_r;
  uhvsr_pkg::out_item_t out_item_r;

  // Architectural registers.
  uhvsr_pkg::regs_t     regs_r;
  uhvsr_pkg::regs_t     regs_nxt;
  logic [3:0]           port_count_r;

  uhvsr_pkg::out_item_t result;
  logic                 advance;

  // The request in the input register moves on whenever the result register
  // is empty or is being emptied in this cycle. Register updates happen at
  // the same edge, so each request sees the effects of all earlier ones.
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  uhvsr_exec u_exec (
    .item       (in_item_r),
    .regs       (regs_r),
    .port_count (port_count_r),
    .regs_nxt   (regs_nxt),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      port_count_r <= 4'd3;
      regs_r       <= '{control_word:    uhvsr_pkg::CTL_RESET,
                        media_count:     12'h000,
                        overflow_flag:   1'b0,
                        descriptor_flag: 1'b0};
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        regs_r      <= regs_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        port_count_r <= cfg_data;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

endmodule

>>> rtl/uhvsr_checker.sv
// ----------------------------------------------------------------------------
// uhvsr_checker
// Port-level checks of the vendor status register block.
// ----------------------------------------------------------------------------
`include "usb_host_vendor_status_registers_assert.svh"

module uhvsr_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input uhvsr_pkg::out_item_t out_data,
  input logic                 cfg_ready
);

  // A stalled result holds its value.
  `UHVSR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // No result is offered right after a reset cycle.
  `UHVSR_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid, "result valid after reset")

  // With the result register empty, the block always takes a request.
  `UHVSR_ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !out_valid, in_ready && cfg_ready, "not ready while result register empty")

  // Only writes clear the overrun and only reads return data.
  `UHVSR_ASSERT_IMPLY(a_clear_no_data, clk, rst_n, out_valid && out_data.clear_overrun, out_data.read_data == 32'h0, "overrun clear with read data")

endmodule

bind usb_host_vendor_status_registers uhvsr_checker u_uhvsr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

>>> test/tb_usb_host_vendor_status_registers.sv
// ----------------------------------------------------------------------------
// tb_usb_host_vendor_status_registers
// Self-checking bench for the vendor control and status register block.
// Requests stream in over a valid/ready channel with random gaps. A model
// kept in the bench predicts every result from its own copy of the control
// word, the status word and the port count. Results are taken with random
// stalls and compared field by field. The port count changes between phases,
// only while nothing is in flight.
// ----------------------------------------------------------------------------
module tb_usb_host_vendor_status_registers;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no handshake on any channel before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 1000;
  // Margin waited after the last result before the block counts as idle.
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned RANDOM_PER_PHASE = 100;
  // Status bits that a write of one clears: overflow and the sticky flags.
  localparam logic [31:0] STATUS_W1C_MASK = 32'h003f_0000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  uhvsr_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  uhvsr_pkg::out_item_t out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [3:0]           cfg_data = 4'd0;

  usb_host_vendor_status_registers DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Bench copy of the block's registers. Only the monitor changes the two
  // words; the port count changes only while the block is idle.
  logic [31:0] ctl_word = uhvsr_pkg::CTL_RESET;
  logic [31:0] stat_word = 32'h0;
  logic [3:0]  hub_ports = 4'd3;

  uhvsr_pkg::in_item_t  request_queue[$];
  uhvsr_pkg::out_item_t expected_replies[$];

  int unsigned in_sent = 0;
  int unsigned in_taken = 0;
  int unsigned out_taken = 0;
  int unsigned out_seen = 0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatch_count = 0;
  // When set, both sides run back to back with no idling.
  bit          no_idle = 1'b0;

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  // Byte mask of an access. Sizes of four and above cover the whole word.
  function automatic logic [31:0] access_mask(input logic [2:0] bytes);
    logic [63:0] m;
    if (bytes >= 3'd4) begin
      return 32'hffff_ffff;
    end
    m = (64'd1 << (8 * bytes)) - 64'd1;
    return m[31:0];
  endfunction

  // Root hub state code of one port, the first matching condition winning.
  function automatic logic [3:0] hub_port_state(input logic [8:0] pc);
    if (!pc[8]) return uhvsr_pkg::PORT_UNPOWERED;
    if (!pc[0]) return uhvsr_pkg::PORT_DISCONNECTED;
    if (pc[4])  return uhvsr_pkg::PORT_RESETTING;
    if (pc[2])  return uhvsr_pkg::PORT_SUSPENDED;
    if (pc[1])  return uhvsr_pkg::PORT_ENABLED;
    return uhvsr_pkg::PORT_DISABLED;
  endfunction

  // Applies one accepted request to the bench registers and queues the
  // result the block must return for it.
  task automatic predict_register_access(input uhvsr_pkg::in_item_t r);
    uhvsr_pkg::out_item_t e;
    logic [9:0]  widx;
    logic [4:0]  sh;
    logic [31:0] v;
    logic [31:0] lane;
    logic [31:0] w;
    widx = r.address[11:2];
    sh = {r.address[1:0], 3'b000};
    e = '0;
    case (r.operation)
      uhvsr_pkg::OP_READ: begin
        v = 32'h0;
        if (widx == uhvsr_pkg::WORD_CTL) begin
          v = ctl_word;
        end else if (widx == uhvsr_pkg::WORD_STATUS) begin
          // The live overrun status is merged in; it is never stored.
          v = stat_word;
          if (r.schedule_overrun) v[uhvsr_pkg::STAT_SCHED_BIT] = 1'b1;
        end else if (widx == uhvsr_pkg::WORD_HUB) begin
          if (hub_ports >= 4'd1) v[3:0] = hub_port_state(r.port_one_control);
          if (hub_ports >= 4'd2) v[11:8] = hub_port_state(r.port_two_control);
        end
        e.read_data = (v >> sh) & access_mask(r.access_size);
      end
      uhvsr_pkg::OP_WRITE: begin
        // Lanes past byte 3 fall off the top of the word.
        lane = (r.access_size >= 3'd4) ? 32'hffff_ffff : (access_mask(r.access_size) << sh);
        w = (r.write_data << sh) & lane;
        if (widx == uhvsr_pkg::WORD_CTL) begin
          ctl_word = (ctl_word & ~lane) | (w & uhvsr_pkg::CTL_WRMASK);
        end else if (widx == uhvsr_pkg::WORD_STATUS) begin
          if (|w[11:0]) stat_word[11:0] = 12'h0;
          stat_word = stat_word & ~(w & STATUS_W1C_MASK);
          e.clear_overrun = w[uhvsr_pkg::STAT_SCHED_BIT];
        end
      end
      uhvsr_pkg::OP_MEDIA_ERR: begin
        // The counter sticks at its maximum and flags the lost event.
        if (stat_word[11:0] == uhvsr_pkg::CNT_MAX) stat_word[uhvsr_pkg::STAT_OVFL_BIT] = 1'b1;
        else stat_word[11:0] = stat_word[11:0] + 12'd1;
      end
      default: begin
        stat_word[uhvsr_pkg::STAT_DESC_BIT] = 1'b1;
      end
    endcase
    e.big_endian_mode = ctl_word[0];
    e.consistency_check_mode = ctl_word[1];
    expected_replies.push_back(e);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_reply(input uhvsr_pkg::out_item_t got);
    uhvsr_pkg::out_item_t want;
    if (expected_replies.size() == 0) begin
      report_mismatch("unexpected result", got.read_data, 32'h0);
    end else begin
      want = expected_replies.pop_front();
      if (got.read_data !== want.read_data)
        report_mismatch("read_data", got.read_data, want.read_data);
      if (got.big_endian_mode !== want.big_endian_mode)
        report_mismatch("big_endian_mode", 32'(got.big_endian_mode),
                        32'(want.big_endian_mode));
      if (got.consistency_check_mode !== want.consistency_check_mode)
        report_mismatch("consistency_check_mode", 32'(got.consistency_check_mode),
                        32'(want.consistency_check_mode));
      if (got.clear_overrun !== want.clear_overrun)
        report_mismatch("clear_overrun", 32'(got.clear_overrun),
                        32'(want.clear_overrun));
    end
  endtask

  // Request driver. A request stays on the bus until it is taken; then the
  // next one follows after a drawn number of empty cycles.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_sent == in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (request_queue.size() > 0) begin
        in_data <= request_queue.pop_front();
        in_valid <= 1'b1;
        in_sent++;
        send_gap = draw_wait();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: after each taken result, ready drops for a drawn stall.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_taken != out_seen) begin
        out_seen = out_taken;
        recv_stall = draw_wait();
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on every accepted request, checks every taken result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_register_access(in_data);
        in_taken++;
      end
      if (out_valid && out_ready) begin
        check_reply(out_data);
        out_taken++;
      end
    end
  end

  // Watchdog on cycles in which no channel completes a handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_usb_host_vendor_status_registers NOT OK");
        $finish;
      end
    end
  end

  function automatic uhvsr_pkg::in_item_t make_req(input logic [1:0] op,
                                                   input logic [11:0] addr,
                                                   input logic [2:0] bytes,
                                                   input logic [31:0] data,
                                                   input logic [8:0] p1,
                                                   input logic [8:0] p2,
                                                   input logic overrun);
    uhvsr_pkg::in_item_t r;
    r.operation = op;
    r.address = addr;
    r.access_size = bytes;
    r.write_data = data;
    r.port_one_control = p1;
    r.port_two_control = p2;
    r.schedule_overrun = overrun;
    return r;
  endfunction

  // Random request, aimed mostly at the three implemented register words.
  function automatic uhvsr_pkg::in_item_t random_req();
    uhvsr_pkg::in_item_t r;
    int unsigned pick;
    logic [1:0]  lane;
    pick = $urandom_range(0, 99);
    if (pick < 40)      r.operation = uhvsr_pkg::OP_READ;
    else if (pick < 70) r.operation = uhvsr_pkg::OP_WRITE;
    else if (pick < 90) r.operation = uhvsr_pkg::OP_MEDIA_ERR;
    else                r.operation = uhvsr_pkg::OP_DESC_ERR;
    lane = 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 9);
    if (pick < 3)      r.address = {uhvsr_pkg::WORD_CTL, lane};
    else if (pick < 6) r.address = {uhvsr_pkg::WORD_STATUS, lane};
    else if (pick < 8) r.address = {uhvsr_pkg::WORD_HUB, lane};
    else               r.address = 12'($urandom_range(0, 4095));
    if ($urandom_range(0, 4) == 0) r.access_size = 3'($urandom_range(0, 7));
    else                           r.access_size = 3'($urandom_range(1, 4));
    r.write_data = $urandom;
    // Some status writes leave the counter alone and only touch the flags.
    if (r.operation == uhvsr_pkg::OP_WRITE && r.address[11:2] == uhvsr_pkg::WORD_STATUS &&
        $urandom_range(0, 1))
      r.write_data = r.write_data & 32'hffff_f000;
    r.port_one_control = 9'($urandom_range(0, 511));
    r.port_two_control = 9'($urandom_range(0, 511));
    r.schedule_overrun = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic write_port_count(input logic [3:0] n);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= n;
    do @(posedge clk); while (!cfg_ready);
    hub_ports = n;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Holds the sender until every queued request is taken and every result
  // is back, then lets the pipeline settle.
  task automatic wait_drained();
    while (request_queue.size() > 0 || in_sent != in_taken || expected_replies.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [3:0] phase_ports [0:6];

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests: both port codes are visible with two ports.
    write_port_count(4'd2);
    // Reset value of the control word, then a single byte of it.
    request_queue.push_back(make_req(uhvsr_pkg::OP_READ, 12'h000, 3'd4, 32'h0,
                                     9'h000, 9'h000, 1'b0));
    request_queue.push_back(make_req(uhvsr_pkg::OP_READ, 12'h003, 3'd1, 32'h0,
                                     9'h000, 9'h000, 1'b0));
    // Full write of ones: only writable bits stick.
    request_queue.push_back(make_req(uhvsr_pkg::OP_WRITE, 12'h000, 3'd4, 32'hffff_ffff,
                                     9'h000, 9'h000, 1'b0));
    // Oversized access counts as a full word.
    request_queue.push_back(make_req(uhvsr_pkg::OP_READ, 12'h001, 3'd7, 32'h0,
                                     9'h1ff, 9'h1ff, 1'b1));
    request_queue.push_back(make_req(uhvsr_pkg::OP_WRITE, 12'h003, 3'd1, 32'h0000_0000,
                                     9'h000, 9'h000, 1'b0));
    // Lanes that run past the end of the word are dropped.
    request_queue.push_back(make_req(uhvsr_pkg::OP_WRITE, 12'h002, 3'd3, 32'h00ff_ffff,
                                     9'h000, 9'h000, 1'b0));
    // A zero-byte write changes nothing.
    request_queue.push_back(make_req(uhvsr_pkg::OP_WRITE, 12'h000, 3'd0, 32'hffff_ffff,
                                     9'h000, 9'h000, 1'b0));
    request_queue.push_back(make_req(uhvsr_pkg::OP_WRITE, 12'h000, 3'd2, 32'h0000_0000,
                                     9'h000, 9'h000, 1'b0));
    request_queue.push_back(make_req(uhvsr_pkg::OP_WRITE, 12'h000, 3'd1, 32'h0000_0001,
                                     9'h000, 9'h000, 1'b0));
    request_queue.push_back(make_req(uhvsr_pkg::OP_MEDIA_ERR, 12'h000, 3'd4, 32'h0,
                                     9'h000, 9'h000, 1'b0));
    request_queue.push_back(make_req(uhvsr_pkg::OP_MEDIA_ERR, 12'hfff, 3'd0, 32'hffff_ffff,
                                     9'h1ff, 9'h1ff, 1'b1));
    request_queue.push_back(make_req(uhvsr_pkg::OP_DESC_ERR, 12'h004, 3'd4, 32'h0,
                                     9'h000, 9'h000, 1'b0));
    // Status read with the live overrun bit merged in, then a zero-byte read.
    request_queue.push_back(make_req(uhvsr_pkg::OP_READ, 12'h004, 3'd4, 32'h0,
                                     9'h000, 9'h000, 1'b1));
    request_queue.push_back(make_req(uhvsr_pkg::OP_READ, 12'h004, 3'd0, 32'h0,
                                     9'h000, 9'h000, 1'b1));
    // Writing the overrun bit requests the host-side clear.
    request_queue.push_back(make_req(uhvsr_pkg::OP_WRITE, 12'h004, 3'd4, 32'h0010_0000,
                                     9'h000, 9'h000, 1'b0));
    request_queue.push_back(make_req(uhvsr_pkg::OP_READ, 12'h006, 3'd1, 32'h0,
                                     9'h000, 9'h000, 1'b0));
    // Lane write that clears overflow and descriptor flags but not the count.
    request_queue.push_back(make_req(uhvsr_pkg::OP_WRITE, 12'h006, 3'd1, 32'h0000_0005,
                                     9'h000, 9'h000, 1'b0));
    request_queue.push_back(make_req(uhvsr_pkg::OP_WRITE, 12'h004, 3'd1, 32'h0000_0001,
                                     9'h000, 9'h000, 1'b0));
    // Writes to any other word are ignored.
    request_queue.push_back(make_req(uhvsr_pkg::OP_WRITE, 12'h034, 3'd4, 32'hffff_ffff,
                                     9'h000, 9'h000, 1'b0));
    // Every port state code appears in the hub word.
    request_queue.push_back(make_req(uhvsr_pkg::OP_READ, 12'h034, 3'd4, 32'h0,
                                     9'h000, 9'h100, 1'b0));
    request_queue.push_back(make_req(uhvsr_pkg::OP_READ, 12'h034, 3'd4, 32'h0,
                                     9'h111, 9'h105, 1'b0));
    request_queue.push_back(make_req(uhvsr_pkg::OP_READ, 12'h034, 3'd2, 32'h0,
                                     9'h103, 9'h101, 1'b0));
    request_queue.push_back(make_req(uhvsr_pkg::OP_READ, 12'hfff, 3'd4, 32'h0,
                                     9'h1ff, 9'h1ff, 1'b1));
    request_queue.push_back(make_req(uhvsr_pkg::OP_WRITE, 12'hffc, 3'd4, 32'h0000_0000,
                                     9'h000, 9'h000, 1'b0));
    request_queue.push_back(make_req(uhvsr_pkg::OP_READ, 12'h035, 3'd1, 32'h0,
                                     9'h1ff, 9'h1ff, 1'b0));
    wait_drained();

    // Random phases, each under its own port count. Between phases the
    // sender waits for every result, and two phases run with no idling.
    phase_ports[0] = 4'd0;
    phase_ports[1] = 4'd1;
    phase_ports[2] = 4'd15;
    phase_ports[3] = 4'd3;
    phase_ports[4] = 4'($urandom_range(0, 15));
    phase_ports[5] = 4'($urandom_range(0, 15));
    phase_ports[6] = 4'd2;
    for (int p = 0; p < 7; p++) begin
      write_port_count(phase_ports[p]);
      no_idle = (p == 2 || p == 5);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) request_queue.push_back(random_req());
      wait_drained();
    end
    no_idle = 1'b0;

    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("tb_usb_host_vendor_status_registers OK");
    end else begin
      $display("tb_usb_host_vendor_status_registers NOT OK");
    end
    $finish;
  end

endmodule
